### hw/rtl/skg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scalar Kalman GARCH step core.
// Depends on nothing. Used by skg_div and scalar_kalman_garch_step_core.

package skg_pkg;

   // Fixed-point word format (Q16.16)
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INIT_VARIANCE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INIT_STATE    = 1'd1;
   localparam int INIT_VAR_BITS = 31;

   // Fault codes
   localparam logic [1:0] FAULT_OK  = 2'd0;
   localparam logic [1:0] FAULT_SAT = 2'd1;
   localparam logic [1:0] FAULT_DEN = 2'd2;

   typedef struct packed {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] obs;
      logic               obs_missing;
      logic               series_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] innov_var;
      logic signed [31:0] gain;
      logic signed [31:0] prior_state;
      logic signed [31:0] prior_variance;
      logic [1:0]         fault;
   } rsp_payload_type;

   // Divider request: magnitudes only, divisor nonzero
   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] dividend;
      logic [WORD_BITS-1:0] divisor;
   } div_req_type;

   // Divider status: big means the quotient does not fit in WORD_BITS bits
   typedef struct packed {
      logic                 done;
      logic                 big;
      logic [WORD_BITS-1:0] quot;
   } div_rsp_type;

endpackage

### hw/rtl/skg_div.sv
`timescale 1ns / 1ps
// Iterative unsigned divider, two quotient bits a cycle: (dividend << FRAC_BITS) / divisor.
// Depends on skg_pkg.

module skg_div (
   input  logic                clock,
   input  logic                reset,
   input  skg_pkg::div_req_type div_req,
   output skg_pkg::div_rsp_type div_rsp
);

   localparam int W    = skg_pkg::WORD_BITS;
   localparam int F    = skg_pkg::FRAC_BITS;
   localparam int ITER = W / 2;
   localparam int CW   = $clog2(ITER);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  low_ff, low_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          big_ff, big_in;

   logic [W:0]    step1_rem, step1_nxt, step2_rem, step2_nxt;
   logic          step1_ge, step2_ge;

   // Two restoring steps per cycle
   always_comb begin
      step1_rem = {rem_ff, low_ff[W-1]};
      step1_ge  = step1_rem >= {1'b0, dvs_ff};
      step1_nxt = step1_ge ? step1_rem - {1'b0, dvs_ff} : step1_rem;
      step2_rem = {step1_nxt[W-1:0], low_ff[W-2]};
      step2_ge  = step2_rem >= {1'b0, dvs_ff};
      step2_nxt = step2_ge ? step2_rem - {1'b0, dvs_ff} : step2_rem;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      big_in  = big_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         // top FRAC_BITS of the shifted dividend seed the remainder
         rem_in  = div_req.dividend >> (W - F);
         low_in  = div_req.dividend << F;
         quot_in = '0;
         dvs_in  = div_req.divisor;
         big_in  = (div_req.dividend >> (W - F)) >= div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = step2_nxt[W-1:0];
         low_in  = low_ff << 2;
         quot_in = {quot_ff[W-3:0], step1_ge, step2_ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      big_ff  <= big_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.big  = big_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### hw/rtl/scalar_kalman_garch_step_core.sv
`timescale 1ns / 1ps
// Scalar Kalman filter step for a time-varying GARCH(1,1) model, Q16.16 saturating.
// Depends on skg_pkg and skg_div.
//
// Each request transfer carries a, b, c, an observation y and two flags; each one
// produces exactly one response transfer with F = P + 1, the gain
// K = ((a+b)P + a) / F, the prior state X and variance P, and a fault code. The
// core then advances X and P (propagation only when the observation is missing)
// and forces the next X to zero when X + c/(1-a-b) would be negative. A series
// start flag reloads X and P from the two configuration registers before the step.
// One item at a time: req_ready is high only while the sequencer is idle. An item's
// span from request transfer to the next request transfer is set mainly by two
// runs of the shared two-bit-per-cycle divider (gain, then clamp quotient); the
// clamp run overlaps the sweep of the shared 32x32 multiplier. A zero F skips the
// gain division and a zero 1-a-b skips the clamp division, shortening the item.
// The response sits in an output register, so a stalled response holds only the
// final write-back, not the next request transfer. Configuration writes are always
// accepted (csr_ready high) and should only be made while the core is idle.

module scalar_kalman_garch_step_core (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  skg_pkg::req_payload_type     req_data,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output skg_pkg::rsp_payload_type     rsp_data,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [skg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                  csr_wdata
);

   localparam int W  = skg_pkg::WORD_BITS;
   localparam int F  = skg_pkg::FRAC_BITS;
   localparam int IV = skg_pkg::INIT_VAR_BITS;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic signed [2*W-1:0] RND = {{(2*W-F){1'b0}}, {F{1'b1}}};

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SUM   = 4'd1;
   localparam logic [3:0] ST_MUL1  = 4'd2;
   localparam logic [3:0] ST_NUM   = 4'd3;
   localparam logic [3:0] ST_KDIV  = 4'd4;
   localparam logic [3:0] ST_KWAIT = 4'd5;
   localparam logic [3:0] ST_CDIV  = 4'd6;
   localparam logic [3:0] ST_MA    = 4'd7;
   localparam logic [3:0] ST_MB    = 4'd8;
   localparam logic [3:0] ST_MC    = 4'd9;
   localparam logic [3:0] ST_MD    = 4'd10;
   localparam logic [3:0] ST_ME    = 4'd11;
   localparam logic [3:0] ST_CWAIT = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   // Saturate a one-bit-wider sum into the word
   function automatic logic signed [W-1:0] sat_w(input logic [W:0] v);
      if (v[W] != v[W-1]) begin
         return v[W] ? WMIN : WMAX;
      end
      return v[W-1:0];
   endfunction

   function automatic logic ovf_w(input logic [W:0] v);
      return v[W] ^ v[W-1];
   endfunction

   function automatic logic [W:0] add_w(input logic [W-1:0] x, input logic [W-1:0] y);
      return {x[W-1], x} + {y[W-1], y};
   endfunction

   function automatic logic [W:0] sub_w(input logic [W-1:0] x, input logic [W-1:0] y);
      return {x[W-1], x} - {y[W-1], y};
   endfunction

   function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // Product scaled down by FRAC_BITS, truncating toward zero
   function automatic logic signed [2*W-1:0] mq_shift(input logic signed [2*W-1:0] p);
      logic signed [2*W-1:0] t;
      t = p + (p[2*W-1] ? RND : '0);
      return t >>> F;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [3:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   skg_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [IV-1:0]           init_var_ff, init_var_in;
   logic signed [W-1:0]     init_state_ff, init_state_in;
   logic signed [W-1:0]     x_ff, x_in;          // est_state
   logic signed [W-1:0]     p_ff, p_in;          // est_variance
   logic                    sat_ff, sat_in;

   logic signed [W-1:0]     a_ff, a_in, b_ff, b_in, c_ff, c_in, y_ff, y_in;
   logic                    miss_ff, miss_in;
   logic signed [W-1:0]     s_ff, s_in, f_ff, f_in, den_ff, den_in;
   logic signed [W-1:0]     m1_ff, m1_in, num_ff, num_in, k_ff, k_in;
   logic signed [W-1:0]     d_ff, d_in, e_ff, e_in, t_ff, t_in;
   logic signed [W-1:0]     p2_ff, p2_in, x2_ff, x2_in;
   logic signed [2*W-1:0]   prod_ff, prod_in;

   // ---------------------------------------------------------------- shared units
   logic signed [W-1:0]     mul_x, mul_y;
   logic signed [2*W-1:0]   mq_sh;
   logic                    mq_o;
   logic signed [W-1:0]     mq_v;
   logic signed [W-1:0]     op_g, op_h, op_k;

   skg_pkg::div_req_type    div_req;
   skg_pkg::div_rsp_type    div_rsp;

   logic [W:0]              sum_ab, sum_pf, sub_1a, sub_db, sum_ma, sub_sk, sub_ak, sum_tm;
   logic                    k_neg, k_sat, c_neg, cl_neg;
   logic [W+1:0]            q_ext, q_sgn, x_ext, cl_sum;

   skg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Missing observation: propagate with a+b; otherwise correct with a+b-K
   assign op_g = miss_ff ? s_ff : d_ff;
   assign op_h = miss_ff ? a_ff : e_ff;
   assign op_k = miss_ff ? '0 : k_ff;

   // Operand select for the shared multiplier, product registered
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_x = s_ff;
            mul_y = p_ff;
         end
         ST_MA: begin
            mul_x = m1_ff;
            mul_y = op_g;
         end
         ST_MB: begin
            mul_x = a_ff;
            mul_y = op_h;
         end
         ST_MC: begin
            mul_x = op_g;
            mul_y = x_ff;
         end
         ST_MD: begin
            mul_x = op_k;
            mul_y = y_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      prod_in = (2*W)'(mul_x) * (2*W)'(mul_y);
   end

   // Scale and saturate the previous product
   always_comb begin
      mq_sh = mq_shift(prod_ff);
      mq_o  = !((mq_sh[2*W-1:W-1] == '0) || (mq_sh[2*W-1:W-1] == '1));
      mq_v  = mq_o ? (mq_sh[2*W-1] ? WMIN : WMAX) : mq_sh[W-1:0];
   end

   assign sum_ab = add_w(a_ff, b_ff);
   assign sum_pf = add_w(p_ff, ONE);
   assign sub_1a = sub_w(ONE, a_ff);
   assign sub_db = sub_w(den_ff, b_ff);
   assign sum_ma = add_w(mq_v, a_ff);
   assign sub_sk = sub_w(s_ff, k_ff);
   assign sub_ak = sub_w(a_ff, k_ff);
   assign sum_tm = add_w(t_ff, mq_v);

   // Gain from quotient magnitude: a negative result may reach WMIN exactly
   assign k_neg = num_ff[W-1] ^ f_ff[W-1];
   assign k_sat = div_rsp.big || (k_neg ? (div_rsp.quot[W-1] && |div_rsp.quot[W-2:0])
                                        : div_rsp.quot[W-1]);

   // Exact sign of X' + c/(1-a-b); a quotient beyond the word range decides alone
   assign c_neg  = c_ff[W-1] ^ den_ff[W-1];
   assign q_ext  = {2'b00, div_rsp.quot};
   assign q_sgn  = c_neg ? (~q_ext + 1'b1) : q_ext;
   assign x_ext  = {{2{x2_ff[W-1]}}, x2_ff};
   assign cl_sum = x_ext + q_sgn;
   assign cl_neg = div_rsp.big ? c_neg : cl_sum[W+1];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      sat_in       = sat_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      y_in         = y_ff;
      miss_in      = miss_ff;
      s_in         = s_ff;
      f_in         = f_ff;
      den_in       = den_ff;
      m1_in        = m1_ff;
      num_in       = num_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      t_in         = t_ff;
      p2_in        = p2_ff;
      x2_in        = x2_ff;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in    = req_data.coef_a;
               b_in    = req_data.coef_b;
               c_in    = req_data.coef_c;
               y_in    = req_data.obs;
               miss_in = req_data.obs_missing;
               sat_in  = 1'b0;
               // reload the series start values before this step
               if (req_data.series_start) begin
                  p_in = W'(init_var_ff);
                  x_in = init_state_ff;
               end
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            s_in     = sat_w(sum_ab);
            f_in     = sat_w(sum_pf);
            den_in   = sat_w(sub_1a);
            sat_in   = sat_ff | ovf_w(sum_ab) | ovf_w(sum_pf) | ovf_w(sub_1a);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            den_in   = sat_w(sub_db);
            sat_in   = sat_ff | ovf_w(sub_db);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            m1_in    = mq_v;
            num_in   = sat_w(sum_ma);
            sat_in   = sat_ff | mq_o | ovf_w(sum_ma);
            state_in = ST_KDIV;
         end
         ST_KDIV: begin
            if (f_ff == '0) begin
               // zero F: gain takes the numerator's sign at full scale
               sat_in   = 1'b1;
               k_in     = (num_ff == '0) ? '0 : (num_ff[W-1] ? WMIN : WMAX);
               state_in = ST_CDIV;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = mag_w(num_ff);
               div_req.divisor  = mag_w(f_ff);
               state_in         = ST_KWAIT;
            end
         end
         ST_KWAIT: begin
            if (div_rsp.done) begin
               if (k_sat) begin
                  sat_in = 1'b1;
                  k_in   = k_neg ? WMIN : WMAX;
               end else begin
                  k_in   = k_neg ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
               end
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            // launch the clamp quotient; it runs under the multiply sweep
            if (den_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = mag_w(c_ff);
               div_req.divisor  = mag_w(den_ff);
            end
            d_in = sat_w(sub_sk);
            e_in = sat_w(sub_ak);
            if (!miss_ff) begin
               sat_in = sat_ff | ovf_w(sub_sk) | ovf_w(sub_ak);
            end
            state_in = ST_MA;
         end
         ST_MA: begin
            state_in = ST_MB;
         end
         ST_MB: begin
            t_in     = mq_v;
            sat_in   = sat_ff | mq_o;
            state_in = ST_MC;
         end
         ST_MC: begin
            p2_in    = sat_w(sum_tm);
            sat_in   = sat_ff | mq_o | ovf_w(sum_tm);
            state_in = ST_MD;
         end
         ST_MD: begin
            t_in     = mq_v;
            sat_in   = sat_ff | mq_o;
            state_in = ST_ME;
         end
         ST_ME: begin
            x2_in    = sat_w(sum_tm);
            sat_in   = sat_ff | mq_o | ovf_w(sum_tm);
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (den_ff == '0) begin
               state_in = ST_OUT;
            end else if (div_rsp.done) begin
               if (cl_neg) begin
                  x2_in = '0;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free, then write back
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.innov_var      = f_ff;
               rsp_in.gain           = k_ff;
               rsp_in.prior_state    = x_ff;
               rsp_in.prior_variance = p_ff;
               rsp_in.fault          = (den_ff == '0) ? skg_pkg::FAULT_DEN
                                     : (sat_ff ? skg_pkg::FAULT_SAT : skg_pkg::FAULT_OK);
               x_in                  = x2_ff;
               p_in                  = p2_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      init_var_in   = init_var_ff;
      init_state_in = init_state_ff;
      if (csr_valid) begin
         unique case (csr_index)
            skg_pkg::REG_INIT_VARIANCE: init_var_in   = csr_wdata[IV-1:0];
            skg_pkg::REG_INIT_STATE:    init_state_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         init_var_ff   <= IV'(1) << F;
         init_state_ff <= '0;
         x_ff          <= '0;
         p_ff          <= '0;
         sat_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         init_var_ff   <= init_var_in;
         init_state_ff <= init_state_in;
         x_ff          <= x_in;
         p_ff          <= p_in;
         sat_ff        <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      y_ff    <= y_in;
      miss_ff <= miss_in;
      s_ff    <= s_in;
      f_ff    <= f_in;
      den_ff  <= den_in;
      m1_ff   <= m1_in;
      num_ff  <= num_in;
      k_ff    <= k_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      t_ff    <= t_in;
      p2_ff   <= p2_in;
      x2_ff   <= x2_in;
      prod_ff <= prod_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
